/* rtl/strided_interval_step_schedule_defines.svh */
// Assertion macros shared by the schedule RTL.
`ifndef STRIDED_INTERVAL_STEP_SCHEDULE_DEFINES_SVH
`define STRIDED_INTERVAL_STEP_SCHEDULE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sis_pkg.sv */
`default_nettype none
package sis_pkg;
  localparam int IDX_W = 3;
  localparam int CFG_W = 4;

  typedef logic [CFG_W-1:0] sis_cfg_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

/* rtl/sis_rem.sv */
`default_nettype none
// Bit-serial restoring remainder, one dividend bit per cycle.
// Divisor must be positive for a meaningful result.
module sis_rem #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvd_r;
  logic [W-1:0]  rem_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [W-1:0]  sh_c;
  logic [W-1:0]  rem_nxt;

  always_comb begin
    sh_c    = {rem_r[W-2:0], dvd_r[W-1]};
    rem_nxt = (sh_c >= divisor) ? sh_c - divisor : sh_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CW'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      cnt_r <= CW'(W);
    end else if (run_r) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

/* rtl/strided_interval_step_schedule.sv */
// A load transaction goes from acceptance through ST_FIN to the output register.
// A query walks the active windows one at a time, each through ST_RD, ST_PRE,
// two bit-serial remainders in the shared divider and ST_ACC, then ST_FIN.
// One transaction at a time: in_stall is high until the sequencer is idle again.
// Reset (rst_n, synchronous): clears the sequencer, output valid, the
// window count register and the per-window live flags.
`default_nettype none
`include "strided_interval_step_schedule_defines.svh"
module strided_interval_step_schedule #(
  parameter int MAX_WINDOWS = 8,
  parameter int STEP_BITS   = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_operation,
  input  wire logic [sis_pkg::IDX_W-1:0]      in_window_index,
  input  wire logic signed [STEP_BITS-1:0]    in_window_start,
  input  wire logic signed [STEP_BITS-1:0]    in_window_stop,
  input  wire logic signed [STEP_BITS-1:0]    in_window_period,
  input  wire logic signed [STEP_BITS-1:0]    in_step,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_hit,
  output logic signed [STEP_BITS-1:0]         out_next_hit,
  output logic signed [STEP_BITS-1:0]         out_prior_hit,
  output logic signed [STEP_BITS-1:0]         out_prior_or_same,
  output logic signed [STEP_BITS-1:0]         out_local_gap,
  output logic                                out_any_live,
  // configuration: active window count
  input  wire logic                           cfg_wr_en,
  input  wire sis_pkg::sis_cfg_t              cfg_wr_data
);
  import sis_pkg::*;

  localparam int W  = STEP_BITS;
  localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;  // table read in flight
  localparam logic [3:0] ST_PRE  = 4'd2;  // per-window setup
  localparam logic [3:0] ST_D1   = 4'd3;  // launch (n - s) mod p
  localparam logic [3:0] ST_W1   = 4'd4;
  localparam logic [3:0] ST_D2   = 4'd5;  // launch |m - s| mod p
  localparam logic [3:0] ST_W2   = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;  // merge window into running result
  localparam logic [3:0] ST_FIN  = 4'd8;  // hand result to output register

  logic [3:0]        state_r, state_nxt;
  sis_cfg_t          act_r;
  logic [MAX_WINDOWS-1:0] live_r;
  logic [CW-1:0]     wi_r;
  logic              op_r;
  logic [W-1:0]      n_r;

  // window table: {start, stop, period}
  logic [3*W-1:0]    mem [MAX_WINDOWS];
  logic [3*W-1:0]    rd_r;
  logic [W-1:0]      s_c, e_c, p_c;

  // per-window scratch
  logic [W-1:0]      d1_r, m_r, t2_r, qp_r, pvw_r;
  logic [W+1:0]      spw_r, nxw_r;
  logic              pos_r, nlts_r, nmin_r, ngte_r, mges_r, r1z_r;

  // running result
  logic              hit_r;
  logic [W-1:0]      nx_r, pv_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_live_r;
  logic [W-1:0]      out_nx_r, out_pv_r, out_pos_r, out_gap_r;

  logic [CW-1:0]     cnt_c;
  logic [MAX_WINDOWS-1:0] mask_c;
  logic              any_live_c;
  logic              in_acc, fin_fire, last_c;
  logic              div_start, div_done;
  logic [W-1:0]      div_dvd, div_rem;
  logic [W-1:0]      nm1_c, nxw_c, pvw_c, pos_c;
  logic              win_hit_c;
  logic              ld_ok_c;

  assign s_c = rd_r[3*W-1:2*W];
  assign e_c = rd_r[2*W-1:W];
  assign p_c = rd_r[W-1:0];

  // counts above the table depth act as the table depth
  assign cnt_c = (32'(act_r) > MAX_WINDOWS) ? CW'(MAX_WINDOWS) : CW'(act_r);

  always_comb begin
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      mask_c[i] = CW'(i) < cnt_c;
    end
  end
  assign any_live_c = |(live_r & mask_c);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ld_ok_c  = 32'(in_window_index) < MAX_WINDOWS;
  assign fin_fire = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign last_c   = (wi_r + CW'(1)) == cnt_c;

  // shared bit-serial remainder unit
  assign div_start = (state_r == ST_D1) || (state_r == ST_D2);
  assign div_dvd   = (state_r == ST_D1) ? d1_r : t2_r;

  sis_rem #(.W(W)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (p_c),
    .done     (div_done),
    .rem      (div_rem)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_operation == OP_QUERY && cnt_c != '0) ? ST_RD : ST_FIN;
        end
      end
      ST_RD:  state_nxt = ST_PRE;
      ST_PRE: state_nxt = ST_D1;
      ST_D1:  state_nxt = ST_W1;
      ST_W1:  if (div_done) state_nxt = ST_D2;
      ST_D2:  state_nxt = ST_W2;
      ST_W2:  if (div_done) state_nxt = ST_ACC;
      ST_ACC: state_nxt = last_c ? ST_FIN : ST_RD;
      ST_FIN: if (fin_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= '0;
      live_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        act_r <= cfg_wr_data;
      end
      // live flag: positive period and stop >= start
      if (in_acc && in_operation == OP_LOAD && ld_ok_c) begin
        live_r[AW'(in_window_index)] <= !in_window_period[W-1] && (in_window_period != '0)
                                       && !(in_window_stop < in_window_start);
      end
    end
  end

  // table memory, registered read at the sequencer's window
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_LOAD && ld_ok_c) begin
      mem[AW'(in_window_index)] <= {in_window_start, in_window_stop, in_window_period};
    end
    rd_r <= mem[wi_r[AW-1:0]];
  end

  // per-window candidates
  assign nm1_c = n_r - W'(1);

  always_comb begin
    // next hit: s when n < s, else nxw_r = s + (d - d mod p) + p; MAXV for a bad period, past stop or above MAXV
    if (!pos_r) begin
      nxw_c = MAXV;
    end else if (nlts_r) begin
      nxw_c = ($signed(e_c) < $signed(s_c)) ? MAXV : s_c;
    end else if ($signed(nxw_r) > $signed({2'b00, MAXV})) begin
      nxw_c = MAXV;
    end else if ($signed(e_c) < $signed(nxw_r[W-1:0])) begin
      nxw_c = MAXV;
    end else begin
      nxw_c = nxw_r[W-1:0];
    end
    // prior hit, clamped to zero
    if (!pos_r || nlts_r || nmin_r || pvw_r[W-1]) begin
      pvw_c = '0;
    end else begin
      pvw_c = pvw_r;
    end
    win_hit_c = pos_r && !nlts_r && ngte_r && r1z_r;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_r  <= in_operation;
          n_r   <= in_step;
          wi_r  <= '0;
          hit_r <= 1'b0;
          nx_r  <= MAXV;
          pv_r  <= '0;
        end
      end
      ST_PRE: begin
        pos_r  <= !p_c[W-1] && (p_c != '0);
        nlts_r <= $signed(n_r) < $signed(s_c);
        nmin_r <= n_r == MINV;
        ngte_r <= !($signed(e_c) < $signed(n_r));
        d1_r   <= n_r - s_c;
        m_r    <= ($signed(e_c) < $signed(nm1_c)) ? e_c : nm1_c;
        spw_r  <= {{2{s_c[W-1]}}, s_c} + {2'b00, p_c};
      end
      ST_D1: begin
        mges_r <= !($signed(m_r) < $signed(s_c));
        t2_r   <= ($signed(m_r) < $signed(s_c)) ? s_c - m_r : m_r - s_c;
      end
      ST_W1: begin
        if (div_done) begin
          qp_r  <= d1_r - div_rem;
          r1z_r <= div_rem == '0;
        end
      end
      ST_D2: begin
        nxw_r <= spw_r + {2'b00, qp_r};
      end
      ST_W2: begin
        if (div_done) begin
          pvw_r <= mges_r ? m_r - div_rem : m_r + div_rem;
        end
      end
      ST_ACC: begin
        hit_r <= hit_r || win_hit_c;
        if ($signed(nxw_c) < $signed(nx_r)) nx_r <= nxw_c;
        if ($signed(pv_r) < $signed(pvw_c)) pv_r <= pvw_c;
        wi_r  <= wi_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // output register; a finished transaction waits in ST_FIN if the slot is full and stalled
  assign pos_c = hit_r ? n_r : pv_r;
  assign out_valid_nxt = fin_fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_live_r <= any_live_c;
      if (op_r == OP_LOAD) begin
        out_hit_r <= 1'b0;
        out_nx_r  <= '0;
        out_pv_r  <= '0;
        out_pos_r <= '0;
        out_gap_r <= '0;
      end else begin
        out_hit_r <= hit_r;
        out_nx_r  <= nx_r;
        out_pv_r  <= pv_r;
        out_pos_r <= pos_c;
        out_gap_r <= nx_r - pos_c;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_next_hit      = out_nx_r;
  assign out_prior_hit     = out_pv_r;
  assign out_prior_or_same = out_pos_r;
  assign out_local_gap     = out_gap_r;
  assign out_any_live      = out_live_r;

  // divider only finishes while the sequencer waits on it
  `SIS_ASSERT_NOW(a_div_done_wait, div_done, (state_r == ST_W1) || (state_r == ST_W2), "divider done outside wait state")
  // an accepted transaction always leaves idle
  `SIS_ASSERT_NEXT(a_acc_busy, in_acc, state_r != ST_IDLE, "accepted transaction did not start")
  // window walk stays inside the active count
  `SIS_ASSERT_NOW(a_wi_range, state_r == ST_ACC, wi_r < cnt_c, "window index past active count")
endmodule
`default_nettype wire

/* dv/strided_interval_step_schedule_test.sv */
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
  bit        hit;
  bit [31:0] next_hit;
  bit [31:0] prior_hit;
  bit [31:0] prior_or_same;
  bit [31:0] local_gap;
  bit        any_live;
} sched_answer_t;

class sched_scoreboard;
  localparam bit [31:0] TOP = 32'h7fff_ffff;
  localparam bit [31:0] BOTTOM = 32'h8000_0000;

  bit [31:0] win_start [8];
  bit [31:0] win_stop [8];
  bit [31:0] win_period [8];
  int unsigned win_count;
  sched_answer_t pending[$];
  int unsigned errs;

  function void set_count(bit [3:0] v);
    win_count = (v > 8) ? 8 : v;
  endfunction

  function bit slt(bit [31:0] a, bit [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function bit [31:0] soonest_after(bit [31:0] n, bit [31:0] s, bit [31:0] e,
                                    bit [31:0] p);
    longint unsigned d, qp, room;
    bit [31:0] nx;
    if ($signed(p) <= 0) return TOP;
    if (slt(n, s)) begin
      nx = s;
    end else begin
      d = {32'b0, 32'(n - s)};
      qp = (d / p) * p;
      room = {32'b0, 32'(TOP - s)};
      if (qp > room || p > room - qp) return TOP;
      nx = s + qp[31:0] + p;
    end
    if (slt(e, nx)) return TOP;
    return nx;
  endfunction

  function bit [31:0] latest_before(bit [31:0] n, bit [31:0] s, bit [31:0] e,
                                    bit [31:0] p);
    bit [31:0] m, pv;
    longint unsigned t;
    if ($signed(p) <= 0 || slt(n, s) || n == BOTTOM) return 0;
    m = n - 1;
    if (slt(e, m)) m = e;
    if (!slt(m, s)) begin
      t = {32'b0, 32'(m - s)};
      pv = s + 32'((t / p) * p);
    end else begin
      t = {32'b0, 32'(s - m)};
      pv = s - 32'((t / p) * p);
    end
    return pv[31] ? 32'd0 : pv;
  endfunction

  // accepted input transaction: update table, queue the expected answer
  function void note_input(bit op, bit [2:0] idx, bit [31:0] s, bit [31:0] e,
                           bit [31:0] p, bit [31:0] n);
    sched_answer_t a;
    bit [31:0] x, b;
    a = '{default: 0};
    a.next_hit = TOP;
    if (op == sis_pkg::OP_LOAD) begin
      win_start[idx] = s;
      win_stop[idx] = e;
      win_period[idx] = p;
    end
    for (int i = 0; i < win_count; i++)
      if ($signed(win_period[i]) > 0 && !slt(win_stop[i], win_start[i])) a.any_live = 1;
    if (op == sis_pkg::OP_LOAD) begin
      a.next_hit = 0;
    end else begin
      for (int i = 0; i < win_count; i++) begin
        if ($signed(win_period[i]) > 0 && !slt(n, win_start[i]) &&
            !slt(win_stop[i], n) && (32'(n - win_start[i]) % win_period[i]) == 0)
          a.hit = 1;
        x = soonest_after(n, win_start[i], win_stop[i], win_period[i]);
        if (slt(x, a.next_hit)) a.next_hit = x;
        b = latest_before(n, win_start[i], win_stop[i], win_period[i]);
        if (slt(a.prior_hit, b)) a.prior_hit = b;
      end
      a.prior_or_same = a.hit ? n : a.prior_hit;
      a.local_gap = a.next_hit - a.prior_or_same;
    end
    pending = {pending, a};
  endfunction

  function void check_result(sched_answer_t got);
    sched_answer_t w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result transaction", $time);
      errs++;
      return;
    end
    w = pending.pop_front();
    if (got.hit != w.hit) begin
      $display("%0t: hit exp %0d got %0d", $time, w.hit, got.hit); errs++;
    end
    if (got.next_hit != w.next_hit) begin
      $display("%0t: next_hit exp %0d got %0d", $time, $signed(w.next_hit),
               $signed(got.next_hit)); errs++;
    end
    if (got.prior_hit != w.prior_hit) begin
      $display("%0t: prior_hit exp %0d got %0d", $time, $signed(w.prior_hit),
               $signed(got.prior_hit)); errs++;
    end
    if (got.prior_or_same != w.prior_or_same) begin
      $display("%0t: prior_or_same exp %0d got %0d", $time,
               $signed(w.prior_or_same), $signed(got.prior_or_same)); errs++;
    end
    if (got.local_gap != w.local_gap) begin
      $display("%0t: local_gap exp %0d got %0d", $time, $signed(w.local_gap),
               $signed(got.local_gap)); errs++;
    end
    if (got.any_live != w.any_live) begin
      $display("%0t: any_live exp %0d got %0d", $time, w.any_live, got.any_live); errs++;
    end
  endfunction
endclass

module strided_interval_step_schedule_test;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_operation = 0;
  logic [2:0] in_window_index = 0;
  logic signed [31:0] in_window_start = 0;
  logic signed [31:0] in_window_stop = 0;
  logic signed [31:0] in_window_period = 0;
  logic signed [31:0] in_step = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit, out_any_live;
  logic signed [31:0] out_next_hit, out_prior_hit, out_prior_or_same, out_local_gap;
  logic cfg_wr_en = 0;
  sis_pkg::sis_cfg_t cfg_wr_data = '0;

  strided_interval_step_schedule i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_window_index(in_window_index), .in_window_start(in_window_start),
    .in_window_stop(in_window_stop), .in_window_period(in_window_period),
    .in_step(in_step),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_next_hit(out_next_hit), .out_prior_hit(out_prior_hit),
    .out_prior_or_same(out_prior_or_same), .out_local_gap(out_local_gap),
    .out_any_live(out_any_live),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sched_scoreboard sched = new();
  int send_idle_pct = 0;   // sender gap chance per cycle
  int stall_pct = 0;       // receiver stall chance per cycle
  int quiet_cycles = 0;    // cycles with no transaction on either channel
  // window table as loaded, kept here to aim query steps at real hits
  bit [31:0] tb_start [8];
  bit [31:0] tb_period [8];

  // receiver side: stall decided at the falling edge
  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);

  // result monitor and watchdog, sampled at the rising edge
  always @(posedge clk) begin
    sched_answer_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.hit = out_hit;
      got.next_hit = out_next_hit;
      got.prior_hit = out_prior_hit;
      got.prior_or_same = out_prior_or_same;
      got.local_gap = out_local_gap;
      got.any_live = out_any_live;
      sched.check_result(got);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("strided_interval_step_schedule_test: errors");
        $finish;
      end
    end
  end

  // one input transaction; valid held until accepted, random gap beforehand,
  // valid low for one cycle afterwards
  task automatic send(bit op, bit [2:0] idx, bit [31:0] s, bit [31:0] e,
                      bit [31:0] p, bit [31:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_window_index <= idx;
    in_window_start <= s;
    in_window_stop <= e;
    in_window_period <= p;
    in_step <= n;
    if (op == sis_pkg::OP_LOAD) begin
      tb_start[idx] = s;
      tb_period[idx] = p;
    end
    do @(posedge clk); while (in_stall);
    sched.note_input(op, idx, s, e, p, n);
    @(negedge clk);
    in_valid <= 0;
    @(negedge clk);
  endtask

  task automatic load(bit [2:0] idx, bit [31:0] s, bit [31:0] e, bit [31:0] p);
    send(sis_pkg::OP_LOAD, idx, s, e, p, $urandom);
  endtask

  task automatic query(bit [31:0] n);
    send(sis_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom, n);
  endtask

  // drain everything, then write the window count while idle
  task automatic set_windows(bit [3:0] v);
    while (sched.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    sched.set_count(v);
  endtask

  // mostly small strided windows, some extreme or disabled ones
  task automatic load_random();
    bit [31:0] s, e, p;
    case ($urandom_range(9))
      0: begin s = $urandom; e = $urandom; p = $urandom; end
      1: begin s = 32'h8000_0000 + $urandom_range(20); e = 32'h7fff_ffff;
               p = $urandom_range(1, 3) << $urandom_range(30); end
      2: begin s = $urandom_range(100) - 50; e = s + $urandom_range(100);
               p = -$urandom_range(2); end
      3: begin s = $urandom_range(100); e = s - $urandom_range(1, 5); p = 1; end
      4: begin s = 32'h7fff_ffff - $urandom_range(40); e = 32'h7fff_ffff;
               p = $urandom_range(1, 9); end
      default: begin s = $urandom_range(200) - 100; e = s + $urandom_range(300);
                     p = $urandom_range(1, 12); end
    endcase
    load($urandom, s, e, p);
  endtask

  // steps aimed near a loaded window, plus full-range noise
  task automatic query_random();
    int w;
    bit [31:0] n;
    w = $urandom_range(7);
    case ($urandom_range(7))
      0: n = $urandom;
      1: n = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                               : 32'h7fff_ffff - $urandom_range(3);
      2: n = tb_start[w] + tb_period[w] * $urandom_range(20);
      default: n = tb_start[w] + $urandom_range(300) - 20;
    endcase
    query(n);
  endtask

  initial begin
    int modes [4][2] = '{'{0, 0}, '{71, 0}, '{0, 71}, '{10, 10}};
    bit [3:0] counts [10] = '{8, 1, 15, 4, 8, 0, 12, 8, 2, 7};
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // every entry written before any query can read it
    load(0, 32'sd0, 32'sd100, 32'sd10);
    load(1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    load(2, -32'sd7, 32'sd50, 32'sd3);
    load(3, 32'sd5, 32'sd80, 32'h8000_0000);
    load(4, 32'sd5, 32'sd80, 32'sd0);
    load(5, 32'sd90, 32'sd10, 32'sd4);
    load(6, 32'h7fff_fff0, 32'h7fff_ffff, 32'sd7);
    load(7, 32'h8000_0000, 32'h8000_0010, 32'sd1);
    set_windows(8);
    query(32'h8000_0000);
    query(32'h7fff_ffff);
    query(0);
    query(-1);
    query(1);
    query(20);
    query(100);
    query(101);
    query(32'h7fff_fff7);
    query(32'h8000_0005);
    load(0, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
    query(32'h5555_5555);
    query(32'haaaa_aaaa);
    set_windows(15);
    query(32'h7fff_fffe);

    // random phases; each starts drained, so the sender has paused at least once
    for (int ph = 0; ph < 10; ph++) begin
      set_windows(ph == 9 ? 4'($urandom) : counts[ph]);
      send_idle_pct = modes[ph % 4][0];
      stall_pct = modes[ph % 4][1];
      for (int k = 0; k < 115; k++)
        if ($urandom_range(99) < 20) load_random();
        else query_random();
    end

    while (sched.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sched.errs == 0 && sched.pending.size() == 0)
      $display("strided_interval_step_schedule_test: clean");
    else
      $display("strided_interval_step_schedule_test: errors");
    $finish;
  end
endmodule
